FILE: design/csc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csc_pkg
// Shared widths, field masks and primary opcode codes for the code signature
// checksum.
// ----------------------------------------------------------------------------
package csc_pkg;

  localparam int unsigned WordW  = 32;
  localparam int unsigned OpW    = 6;
  localparam int unsigned RotAmt = 17;

  localparam logic [WordW-1:0] PrimaryMask = 32'hFC00_0000;
  localparam logic [WordW-1:0] Low6Mask    = 32'h0000_003F;
  localparam logic [WordW-1:0] Mid5Mask    = 32'h0000_07C0;
  localparam logic [WordW-1:0] ImmHiMask   = 32'h03FF_0000;
  localparam logic [WordW-1:0] Low11Mask   = 32'h0000_07FF;

  // primary opcodes with special handling
  localparam logic [OpW-1:0] OpPaired = 6'd4;
  localparam logic [OpW-1:0] OpMulli  = 6'd7;
  localparam logic [OpW-1:0] OpSubfic = 6'd8;
  localparam logic [OpW-1:0] OpImmLo  = 6'd10;
  localparam logic [OpW-1:0] OpImmHi  = 6'd15;
  localparam logic [OpW-1:0] OpMemLo  = 6'd32;
  localparam logic [OpW-1:0] OpMemHi  = 6'd55;
  localparam logic [OpW-1:0] OpBrCr   = 6'd19;
  localparam logic [OpW-1:0] OpInt    = 6'd31;
  localparam logic [OpW-1:0] OpFpD    = 6'd63;
  localparam logic [OpW-1:0] OpFpS    = 6'd59;

  // paired-single sub-opcodes that also keep bits 10:6
  localparam logic [OpW-1:0] PsCmp0   = 6'd0;
  localparam logic [OpW-1:0] PsMr     = 6'd8;
  localparam logic [OpW-1:0] PsNeg    = 6'd16;
  localparam logic [OpW-1:0] PsAdd    = 6'd21;
  localparam logic [OpW-1:0] PsSub    = 6'd22;
  localparam logic [OpW-1:0] FpSLimit = 6'd16;

endpackage

FILE: design/csc_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csc_in_if / csc_out_if
// Valid/ready request channels for instruction words and checksums.
// ----------------------------------------------------------------------------
interface csc_in_if;
  logic                           valid;
  logic                           ready;
  logic [csc_pkg::WordW-1:0]      instr_word;
  logic                           last_word;

  modport source (output valid, output instr_word, output last_word, input ready);
  modport sink   (input valid, input instr_word, input last_word, output ready);
endinterface

interface csc_out_if;
  logic                           valid;
  logic                           ready;
  logic [csc_pkg::WordW-1:0]      checksum;

  modport source (output valid, output checksum, input ready);
  modport sink   (input valid, input checksum, output ready);
endinterface

FILE: design/code_signature_checksum.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// code_signature_checksum
// Opcode signature over a run of instruction words: rotate-left-17 and XOR
// of the kept opcode bits, emitted and cleared on the last word.
// ----------------------------------------------------------------------------
// Pipeline: input register, then sum update into the result register.
// Throughput: one word per cycle, set by the sum update loop; a last word
//   stalls while the result register holds an unaccepted checksum.
// Reset: running sum cleared, both pipeline registers empty.
// ----------------------------------------------------------------------------
module code_signature_checksum (
  input  logic             clk_i,
  input  logic             rst_ni,
  csc_in_if.sink           in_i,
  csc_out_if.source        out_o
);

  logic                      s1_vld_q;
  logic [csc_pkg::WordW-1:0] s1_word_q;
  logic                      s1_last_q;
  logic                      s1_adv;

  logic [csc_pkg::WordW-1:0] sum_q, sum_d;
  logic [csc_pkg::WordW-1:0] kept;

  logic                      out_vld_q;
  logic [csc_pkg::WordW-1:0] out_q;
  logic                      out_free;

  csc_mask u_mask (
    .word_i (s1_word_q),
    .kept_o (kept)
  );

  assign out_free = !out_vld_q || out_o.ready;
  assign s1_adv   = s1_vld_q && (!s1_last_q || out_free);
  assign in_i.ready = !s1_vld_q || s1_adv;

  assign sum_d = {sum_q[csc_pkg::WordW-csc_pkg::RotAmt-1:0],
                  sum_q[csc_pkg::WordW-1:csc_pkg::WordW-csc_pkg::RotAmt]} ^ kept;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
    end else if (in_i.ready) begin
      s1_vld_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.ready && in_i.valid) begin
      s1_word_q <= in_i.instr_word;
      s1_last_q <= in_i.last_word;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q <= '0;
    end else if (s1_adv) begin
      sum_q <= s1_last_q ? '0 : sum_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (out_free) begin
      out_vld_q <= s1_adv && s1_last_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv && s1_last_q) begin
      out_q <= sum_d;
    end
  end

  assign out_o.valid    = out_vld_q;
  assign out_o.checksum = out_q;

endmodule

FILE: design/csc_mask.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csc_mask
// Keeps the primary opcode and the class-dependent extended opcode bits of
// one instruction word; operand bits are cleared.
// ----------------------------------------------------------------------------
module csc_mask (
  input  logic [csc_pkg::WordW-1:0] word_i,
  output logic [csc_pkg::WordW-1:0] kept_o
);

  logic [csc_pkg::OpW-1:0]   op;
  logic [csc_pkg::OpW-1:0]   sub;
  logic [csc_pkg::WordW-1:0] ext;
  logic                      is_imm;

  assign op  = word_i[csc_pkg::WordW-1 -: csc_pkg::OpW];
  assign sub = word_i[csc_pkg::OpW-1:0];

  assign is_imm = (op == csc_pkg::OpMulli) || (op == csc_pkg::OpSubfic)
               || ((op >= csc_pkg::OpImmLo) && (op <= csc_pkg::OpImmHi))
               || ((op >= csc_pkg::OpMemLo) && (op <= csc_pkg::OpMemHi));

  always_comb begin
    ext = '0;
    priority if (op == csc_pkg::OpPaired) begin
      ext = word_i & csc_pkg::Low6Mask;
      if ((sub == csc_pkg::PsCmp0) || (sub == csc_pkg::PsMr) || (sub == csc_pkg::PsNeg)
          || (sub == csc_pkg::PsAdd) || (sub == csc_pkg::PsSub)) begin
        ext = ext | (word_i & csc_pkg::Mid5Mask);
      end
    end else if (is_imm) begin
      ext = word_i & csc_pkg::ImmHiMask;
    end else if ((op == csc_pkg::OpBrCr) || (op == csc_pkg::OpInt)
                 || (op == csc_pkg::OpFpD)) begin
      ext = word_i & csc_pkg::Low11Mask;
    end else if (op == csc_pkg::OpFpS) begin
      ext = word_i & csc_pkg::Low6Mask;
      if (sub < csc_pkg::FpSLimit) begin
        ext = ext | (word_i & csc_pkg::Mid5Mask);
      end
    end else begin
      ext = '0;
    end
  end

  assign kept_o = (word_i & csc_pkg::PrimaryMask) | ext;

endmodule

FILE: bench/code_signature_checksum_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// code_signature_checksum_tb
// Streams runs of instruction words into the checksum block and compares
// every emitted signature with an in-bench rotate/XOR predictor. Both
// channels idle at random in the first two of three phases; the last has no idles.
// ----------------------------------------------------------------------------
module code_signature_checksum_tb;

  localparam int unsigned PhaseWords = 440;
  localparam int unsigned CycleLimit = 200000;
  localparam int unsigned DrainLimit = 5000;
  localparam int unsigned SettleCycles = 12;

  // primary opcodes with no extended bits kept
  localparam logic [csc_pkg::OpW-1:0] OpPlainLo = 6'd9;
  localparam logic [csc_pkg::OpW-1:0] OpPlainHi = 6'd56;

  typedef struct packed {
    logic [csc_pkg::WordW-1:0] word;
    logic                      last;
  } word_req_t;

  logic clk_i;
  logic rst_ni;

  csc_in_if  in_ch ();
  csc_out_if out_ch ();

  code_signature_checksum uut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_ch),
    .out_o (out_ch)
  );

  word_req_t                 pending_words[$];
  logic [csc_pkg::WordW-1:0] sig_expected[$];
  logic [csc_pkg::WordW-1:0] sig_sum = '0;
  logic [csc_pkg::WordW-1:0] exp_sig;
  word_req_t                 drive_req;
  int unsigned               src_idle_pct = 21;
  int unsigned               snk_idle_pct = 54;
  int unsigned               mismatch_count = 0;
  int unsigned               cycle_count = 0;

  function automatic logic [csc_pkg::WordW-1:0] kept_opcode_bits(
      input logic [csc_pkg::WordW-1:0] w);
    logic [csc_pkg::OpW-1:0]   op;
    logic [csc_pkg::WordW-1:0] ext;
    op  = w[31:26];
    ext = '0;
    if (op == csc_pkg::OpPaired) begin
      ext = w & csc_pkg::Low6Mask;
      if (w[5:0] inside {csc_pkg::PsCmp0, csc_pkg::PsMr, csc_pkg::PsNeg,
                         csc_pkg::PsAdd, csc_pkg::PsSub}) ext |= w & csc_pkg::Mid5Mask;
    end else if (op == csc_pkg::OpMulli || op == csc_pkg::OpSubfic ||
                 (op >= csc_pkg::OpImmLo && op <= csc_pkg::OpImmHi) ||
                 (op >= csc_pkg::OpMemLo && op <= csc_pkg::OpMemHi)) begin
      ext = w & csc_pkg::ImmHiMask;
    end else if (op inside {csc_pkg::OpBrCr, csc_pkg::OpInt, csc_pkg::OpFpD}) begin
      ext = w & csc_pkg::Low11Mask;
    end else if (op == csc_pkg::OpFpS) begin
      ext = w & csc_pkg::Low6Mask;
      if (w[5:0] < csc_pkg::FpSLimit) ext |= w & csc_pkg::Mid5Mask;
    end
    return (w & csc_pkg::PrimaryMask) | ext;
  endfunction

  task automatic fold_word(input logic [csc_pkg::WordW-1:0] w, input logic last);
    logic [csc_pkg::WordW-1:0] nxt;
    nxt = {sig_sum[csc_pkg::WordW-csc_pkg::RotAmt-1:0],
           sig_sum[csc_pkg::WordW-1:csc_pkg::WordW-csc_pkg::RotAmt]} ^ kept_opcode_bits(w);
    if (last) begin
      sig_expected = {sig_expected, nxt};
      sig_sum = '0;
    end else begin
      sig_sum = nxt;
    end
  endtask

  task automatic report_mismatch(input string what, input logic [csc_pkg::WordW-1:0] exp_v,
                                 input logic [csc_pkg::WordW-1:0] got_v);
    $display("[%0t] %s: expected %08h got %08h", $realtime, what, exp_v, got_v);
    mismatch_count++;
  endtask

  task automatic push_word(input logic [csc_pkg::WordW-1:0] w, input logic last);
    word_req_t r;
    r.word = w;
    r.last = last;
    pending_words = {pending_words, r};
  endtask

  function automatic logic [csc_pkg::WordW-1:0] full_operand(
      input logic [csc_pkg::OpW-1:0] op, input logic [5:0] sub);
    return {op, 20'hFFFFF, sub};
  endfunction

  function automatic logic [csc_pkg::WordW-1:0] random_word();
    logic [csc_pkg::WordW-1:0] w;
    logic [csc_pkg::OpW-1:0]   op;
    w = $urandom;
    case ($urandom_range(7))
      0, 1, 7: op = csc_pkg::OpW'($urandom_range(63));
      2: op = csc_pkg::OpPaired;
      3: op = csc_pkg::OpFpS;
      4: begin
        case ($urandom_range(2))
          0: op = csc_pkg::OpBrCr;
          1: op = csc_pkg::OpInt;
          default: op = csc_pkg::OpFpD;
        endcase
      end
      5: op = csc_pkg::OpW'($urandom_range(csc_pkg::OpMemLo, csc_pkg::OpMemHi));
      default: begin
        case ($urandom_range(3))
          0: op = csc_pkg::OpMulli;
          1: op = csc_pkg::OpSubfic;
          default: op = csc_pkg::OpW'($urandom_range(csc_pkg::OpImmLo, csc_pkg::OpImmHi));
        endcase
      end
    endcase
    if ($urandom_range(3) != 0) w[31:26] = op;
    if (w[31:26] == csc_pkg::OpPaired && $urandom_range(1) == 1) begin
      case ($urandom_range(4))
        0: w[5:0] = csc_pkg::PsCmp0;
        1: w[5:0] = csc_pkg::PsMr;
        2: w[5:0] = csc_pkg::PsNeg;
        3: w[5:0] = csc_pkg::PsAdd;
        default: w[5:0] = csc_pkg::PsSub;
      endcase
    end
    if (w[31:26] == csc_pkg::OpFpS && $urandom_range(1) == 1) begin
      w[5:0] = 6'($urandom_range(csc_pkg::FpSLimit - 1));
    end
    return w;
  endfunction

  task automatic add_random_runs(input int unsigned target);
    int unsigned added;
    int unsigned len;
    added = 0;
    while (added < target) begin
      len = ($urandom_range(9) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 6);
      for (int unsigned i = 0; i < len; i++) push_word(random_word(), i == len - 1);
      added += len;
    end
  endtask

  task automatic add_directed();
    push_word(32'h0000_0000, 1'b1);
    push_word(32'hFFFF_FFFF, 1'b1);
    push_word(full_operand(csc_pkg::OpPaired, csc_pkg::PsCmp0), 1'b1);
    push_word(full_operand(csc_pkg::OpPaired, csc_pkg::PsMr), 1'b1);
    push_word(full_operand(csc_pkg::OpPaired, csc_pkg::PsNeg), 1'b1);
    push_word(full_operand(csc_pkg::OpPaired, csc_pkg::PsAdd), 1'b1);
    push_word(full_operand(csc_pkg::OpPaired, csc_pkg::PsSub), 1'b1);
    push_word(full_operand(csc_pkg::OpPaired, 6'h3F), 1'b1);
    push_word(full_operand(csc_pkg::OpMulli, 6'h3F), 1'b1);
    push_word(full_operand(csc_pkg::OpSubfic, 6'h3F), 1'b1);
    push_word(full_operand(csc_pkg::OpImmLo, 6'h3F), 1'b1);
    push_word(full_operand(csc_pkg::OpImmHi, 6'h3F), 1'b1);
    push_word(full_operand(csc_pkg::OpMemLo, 6'h3F), 1'b1);
    push_word(full_operand(csc_pkg::OpMemHi, 6'h3F), 1'b1);
    push_word(full_operand(csc_pkg::OpBrCr, 6'h3F), 1'b1);
    push_word(full_operand(csc_pkg::OpInt, 6'h3F), 1'b1);
    push_word(full_operand(csc_pkg::OpFpS, csc_pkg::OpW'(csc_pkg::FpSLimit - 1)), 1'b1);
    push_word(full_operand(csc_pkg::OpFpS, csc_pkg::FpSLimit), 1'b1);
    push_word(full_operand(OpPlainLo, 6'h3F), 1'b1);
    push_word(full_operand(OpPlainHi, 6'h3F), 1'b1);
    // multi-word run exercises the rotation
    push_word(32'hFFFF_FFFF, 1'b0);
    push_word(full_operand(csc_pkg::OpMemLo, 6'h2A), 1'b0);
    push_word(32'h8000_0001, 1'b1);
  endtask

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // driver
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_ch.valid <= 1'b0;
      in_ch.instr_word <= '0;
      in_ch.last_word <= 1'b0;
    end else if (!in_ch.valid || in_ch.ready) begin
      if (in_ch.valid) fold_word(in_ch.instr_word, in_ch.last_word);
      if (pending_words.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
        drive_req = pending_words.pop_front();
        in_ch.valid <= 1'b1;
        in_ch.instr_word <= drive_req.word;
        in_ch.last_word <= drive_req.last;
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // monitor
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (sig_expected.size() == 0) begin
          report_mismatch("unexpected checksum", '0, out_ch.checksum);
        end else begin
          exp_sig = sig_expected.pop_front();
          if (out_ch.checksum !== exp_sig) report_mismatch("checksum", exp_sig, out_ch.checksum);
        end
      end
      out_ch.ready <= ($urandom_range(99) >= snk_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    int unsigned waited;
    rst_ni = 1'b0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    for (int unsigned phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          src_idle_pct = 21;
          snk_idle_pct = 54;
          add_directed();
        end
        1: begin
          src_idle_pct = 54;
          snk_idle_pct = 21;
        end
        default: begin
          src_idle_pct = 0;
          snk_idle_pct = 0;
        end
      endcase
      add_random_runs(PhaseWords);
      while (pending_words.size() != 0 || in_ch.valid) @(posedge clk_i);
    end

    waited = 0;
    while (sig_expected.size() != 0 && waited < DrainLimit) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (SettleCycles) @(posedge clk_i);
    while (sig_expected.size() != 0) begin
      report_mismatch("missing checksum", sig_expected.pop_front(), '0);
    end

    if (mismatch_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

FILE: sim.f
design/csc_pkg.sv
design/csc_if.sv
design/csc_mask.sv
design/code_signature_checksum.sv
bench/code_signature_checksum_tb.sv
